// ----- rtl/core/tcqp_pkg.sv -----
package tcqp_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = 5;
    localparam int DUR_W       = 32;
    localparam int FREQ_W      = 16;
    localparam int ENTRY_W     = DUR_W + FREQ_W;
    localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(16);

    // request codes
    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_UPDATE = 2'd1;
    localparam logic [1:0] OP_DRAIN  = 2'd2;
    localparam logic [1:0] OP_TICK   = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [DUR_W-1:0]  duration;
        logic [FREQ_W-1:0] frequency;
    } cmd_t;

endpackage

// ----- rtl/core/tcqp_ram.sv -----
module tcqp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/tcqp_front.sv -----
module tcqp_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              action,
    input  logic [tcqp_pkg::DUR_W-1:0]  duration,
    input  logic [tcqp_pkg::FREQ_W-1:0] frequency,
    output logic                    cmd_valid,
    output tcqp_pkg::cmd_t          cmd,
    input  logic                    cmd_pop
);

    // two-entry request queue between front and back
    tcqp_pkg::cmd_t slot_reg [2];
    tcqp_pkg::cmd_t slot_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push;
    logic       pop;

    assign busy      = (fill_reg == 2'd2);
    assign push      = start && !busy;
    assign cmd_valid = (fill_reg != 2'd0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        case (action)
            tcqp_pkg::OP_PUSH:   slot_next.op = tcqp_pkg::OP_PUSH;
            tcqp_pkg::OP_UPDATE: slot_next.op = tcqp_pkg::OP_UPDATE;
            tcqp_pkg::OP_DRAIN:  slot_next.op = tcqp_pkg::OP_DRAIN;
            default:             slot_next.op = tcqp_pkg::OP_TICK;
        endcase
        slot_next.duration  = duration;
        slot_next.frequency = frequency;
    end

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= slot_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ----- rtl/core/tcqp_back.sv -----
module tcqp_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        queue_limit_we,
    input  logic [tcqp_pkg::CNT_W-1:0]  queue_limit,
    input  logic                        cmd_valid,
    input  tcqp_pkg::cmd_t              cmd,
    output logic                        cmd_pop,
    output logic                        done,
    output logic                        accepted,
    output logic                        powered,
    output logic [tcqp_pkg::FREQ_W-1:0] tone_frequency,
    output logic [tcqp_pkg::CNT_W-1:0]  queue_count,
    output logic                        draining
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    logic [1:0]                    state_reg, state_next;
    logic [tcqp_pkg::PTR_W-1:0]    rp_reg, rp_next;
    logic [tcqp_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [tcqp_pkg::CNT_W-1:0]    limit_reg, limit_next;
    logic                          playing_reg, playing_next;
    logic                          drain_reg, drain_next;
    logic [tcqp_pkg::FREQ_W-1:0]   freq_reg, freq_next;
    logic [tcqp_pkg::DUR_W-1:0]    elapsed_reg, elapsed_next;
    logic [tcqp_pkg::DUR_W-1:0]    target_reg, target_next;
    logic                          acc_reg, acc_next;
    logic                          done_reg, done_next;

    logic                          ram_we;
    logic [tcqp_pkg::PTR_W-1:0]    ram_waddr;
    logic [tcqp_pkg::ENTRY_W-1:0]  ram_rdata;
    logic                          room;

    // slot index wraps naturally: depth is a power of two
    assign ram_waddr = rp_reg + count_reg[tcqp_pkg::PTR_W-1:0];
    assign room = (count_reg < limit_reg)
               && (count_reg < tcqp_pkg::CNT_W'(tcqp_pkg::QUEUE_DEPTH))
               && !drain_reg;

    tcqp_ram #(
        .WIDTH (tcqp_pkg::ENTRY_W),
        .DEPTH (tcqp_pkg::QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({cmd.duration, cmd.frequency}),
        .raddr (rp_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        rp_next      = rp_reg;
        count_next   = count_reg;
        limit_next   = queue_limit_we ? queue_limit : limit_reg;
        playing_next = playing_reg;
        drain_next   = drain_reg;
        freq_next    = freq_reg;
        elapsed_next = elapsed_reg;
        target_next  = target_reg;
        acc_next     = acc_reg;
        done_next    = 1'b0;
        cmd_pop      = 1'b0;
        ram_we       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop  = 1'b1;
                    acc_next = 1'b0;
                    case (cmd.op)
                        tcqp_pkg::OP_PUSH:
                        begin
                            if (room)
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                                acc_next   = 1'b1;
                                state_next = ST_READ;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        tcqp_pkg::OP_UPDATE:
                        begin
                            state_next = ST_READ;
                        end
                        tcqp_pkg::OP_DRAIN:
                        begin
                            drain_next   = 1'b1;
                            playing_next = 1'b0;
                            freq_next    = '0;
                            done_next    = 1'b1;
                        end
                        default:
                        begin
                            if (elapsed_reg != '1)
                            begin
                                elapsed_next = elapsed_reg + 1'b1;
                            end
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            // head entry is fetched here, after any write of the same slot
            ST_READ:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                if (drain_reg)
                begin
                    if (count_reg != '0)
                    begin
                        rp_next    = rp_reg + 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                    else
                    begin
                        drain_next = 1'b0;
                    end
                end
                else if (playing_reg)
                begin
                    if (elapsed_reg >= target_reg)
                    begin
                        playing_next = 1'b0;
                        freq_next    = '0;
                        elapsed_next = '0;
                        target_next  = '0;
                    end
                end
                else if (count_reg != '0)
                begin
                    target_next  = ram_rdata[tcqp_pkg::ENTRY_W-1:tcqp_pkg::FREQ_W];
                    freq_next    = ram_rdata[tcqp_pkg::FREQ_W-1:0];
                    rp_next      = rp_reg + 1'b1;
                    count_next   = count_reg - 1'b1;
                    playing_next = 1'b1;
                    elapsed_next = '0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rp_reg      <= '0;
            count_reg   <= '0;
            limit_reg   <= tcqp_pkg::LIMIT_RESET;
            playing_reg <= 1'b0;
            drain_reg   <= 1'b0;
            freq_reg    <= '0;
            elapsed_reg <= '0;
            target_reg  <= '0;
            acc_reg     <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rp_reg      <= rp_next;
            count_reg   <= count_next;
            limit_reg   <= limit_next;
            playing_reg <= playing_next;
            drain_reg   <= drain_next;
            freq_reg    <= freq_next;
            elapsed_reg <= elapsed_next;
            target_reg  <= target_next;
            acc_reg     <= acc_next;
            done_reg    <= done_next;
        end
    end

    // state only moves while a request is worked, so the regs hold the result
    assign done           = done_reg;
    assign accepted       = acc_reg;
    assign powered        = playing_reg;
    assign tone_frequency = freq_reg;
    assign queue_count    = count_reg;
    assign draining       = drain_reg;

`ifndef SYNTHESIS
    a_freq_off: assert property (@(posedge clk) disable iff (!rst_n)
        !playing_reg |-> freq_reg == '0)
        else $error("tone frequency held while off");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= tcqp_pkg::CNT_W'(tcqp_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

    a_read_exec: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |=> state_reg == ST_EXEC)
        else $error("fetch not followed by execute");

    a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EXEC |=> done_reg && state_reg == ST_IDLE)
        else $error("execute gave no result");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> state_reg == ST_IDLE && cmd_valid)
        else $error("request taken outside idle");
`endif

endmodule

// ----- rtl/core/tone_command_queue_player.sv -----
// Tone command queue player. A request is taken at a clock edge with start high
// and busy low; a two-entry request queue lets up to two wait while one is
// worked. Each request gives exactly one result, shown for one cycle with done
// high; the receiver cannot stall, so sample on done. With the back end idle,
// tick, drain and refused push set done as the back end takes them; update and
// accepted push pass fetch and execute first, after the command memory write
// and its registered read; a request held in the queue adds its wait. queue_limit
// is written with queue_limit_we and should only change while no request is in
// flight. Tick, drain and refused push requests can be taken back to back.
module tone_command_queue_player (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  action,
    input  logic [tcqp_pkg::DUR_W-1:0]  duration,
    input  logic [tcqp_pkg::FREQ_W-1:0] frequency,
    input  logic                        queue_limit_we,
    input  logic [tcqp_pkg::CNT_W-1:0]  queue_limit,
    output logic                        done,
    output logic                        accepted,
    output logic                        powered,
    output logic [tcqp_pkg::FREQ_W-1:0] tone_frequency,
    output logic [tcqp_pkg::CNT_W-1:0]  queue_count,
    output logic                        draining
);

    logic           cmd_valid;
    tcqp_pkg::cmd_t cmd;
    logic           cmd_pop;

    tcqp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .action    (action),
        .duration  (duration),
        .frequency (frequency),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    tcqp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .queue_limit_we (queue_limit_we),
        .queue_limit    (queue_limit),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_pop        (cmd_pop),
        .done           (done),
        .accepted       (accepted),
        .powered        (powered),
        .tone_frequency (tone_frequency),
        .queue_count    (queue_count),
        .draining       (draining)
    );

endmodule
